// ===== hw/rtl/chd_pkg.sv =====
// Package for the compass heading block: payload words, controller and
// datapath command/status structs, CORDIC arctangent table and constants.
// No dependencies.
`default_nettype none

package chd_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 5;

    localparam int XY_W = 28;
    localparam int Z_W  = 24;
    localparam int H_W  = 18;

    localparam logic signed [Z_W-1:0] Z_QUARTER = 24'sd2304000;
    localparam logic signed [Z_W-1:0] Z_HALF_LSB = 24'sd128;
    localparam logic signed [H_W-1:0] FULL_TURN = 18'sd36000;

    localparam logic [27:0] RECIP_100 = 28'd5243;
    localparam logic [15:0] MAP_MUL   = 16'd179;
    localparam logic [32:0] RECIP_239 = 33'd70198;
    localparam logic [8:0]  MAP_KNEE  = 9'd240;
    localparam logic [8:0]  MAP_BASE  = 9'd180;
    localparam logic [15:0] HALF_DEG  = 16'd50;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECLINATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 2'd1;

    localparam logic signed [15:0] DECL_RESET = 16'sd802;
    localparam logic [3:0]         DB_RESET   = 4'd3;

    typedef struct packed {
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
    } t_in_word;

    typedef struct packed {
        logic [15:0] heading_fine;
        logic [8:0]  heading_mapped;
        logic [8:0]  heading_smooth;
    } t_out_word;

    typedef struct packed {
        logic              load;
        logic              iter;
        logic [STEP_W-1:0] step;
        logic              angle;
        logic              wrap;
        logic              div;
        logic              mul;
        logic              recip;
        logic              emit;
    } t_dp_cmd;

    typedef struct packed {
        logic h_ok;
    } t_dp_sts;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ITER,
        S_ANGLE,
        S_WRAP,
        S_DIV,
        S_MUL,
        S_RECIP,
        S_EMIT
    } t_state;

    function automatic logic signed [Z_W-1:0] chd_atan(input logic [STEP_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 24'sd1152000;
            5'd1:    v = 24'sd680065;
            5'd2:    v = 24'sd359328;
            5'd3:    v = 24'sd182400;
            5'd4:    v = 24'sd91554;
            5'd5:    v = 24'sd45822;
            5'd6:    v = 24'sd22916;
            5'd7:    v = 24'sd11459;
            5'd8:    v = 24'sd5730;
            5'd9:    v = 24'sd2865;
            5'd10:   v = 24'sd1432;
            5'd11:   v = 24'sd716;
            5'd12:   v = 24'sd358;
            5'd13:   v = 24'sd179;
            5'd14:   v = 24'sd90;
            5'd15:   v = 24'sd45;
            5'd16:   v = 24'sd22;
            5'd17:   v = 24'sd11;
            5'd18:   v = 24'sd6;
            5'd19:   v = 24'sd3;
            5'd20:   v = 24'sd1;
            5'd21:   v = 24'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/compass_heading_deadband.sv =====
// Compass heading block: CORDIC atan2 of a magnetometer X,Y word, declination
// correction, piecewise degree remap and deadband smoothing.
// Depends on chd_pkg, chd_ctrl and chd_dp.
//
// Input channel: i_in_valid / o_in_stall carry one X,Y word. Output channel:
// o_out_valid / i_out_stall carry heading_fine, heading_mapped and
// heading_smooth. A word moves when valid is high and stall is low.
// Config channel: i_cfg_valid / o_cfg_ready, index 0 = declination,
// index 1 = deadband; other indexes are ignored. Write only while idle.
// One word is processed at a time. The iterative CORDIC unit and a wrap step
// that repeats until the heading lies in range come between input accept
// and output valid.
// The next input word is taken as soon as the result is in the output
// register, even while the receiver stalls it; a second result then waits
// in the datapath until the output register frees.
// Reset restores declination 802, deadband 3, clears the previous smoothed
// heading and drops any pending output word.
`default_nettype none

module compass_heading_deadband
    import chd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_word             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_word                 o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]          i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    chd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    chd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/chd_ctrl.sv =====
// Controller for the compass heading block: sequences load, CORDIC steps,
// wrap, remap and output word handoff. Depends on chd_pkg.
`default_nettype none

module chd_ctrl
    import chd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.step = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_ITER;
                end
            end
            S_ITER: begin
                o_cmd.iter = 1'b1;
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_ANGLE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_ANGLE: begin
                o_cmd.angle = 1'b1;
                n_state     = S_WRAP;
            end
            S_WRAP: begin
                if (i_sts.h_ok) begin
                    n_state = S_DIV;
                end else begin
                    o_cmd.wrap = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_RECIP;
            end
            S_RECIP: begin
                o_cmd.recip = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/chd_dp.sv =====
// Datapath for the compass heading block: config registers, CORDIC vectoring
// registers, wrap, constant-reciprocal remap, deadband and output word.
// Depends on chd_pkg.
`default_nettype none

module chd_dp
    import chd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]          i_cfg_data,
    input  wire t_in_word             i_in_data,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    output t_out_word                 o_out_data
);

    logic signed [15:0]     r_decl;
    logic [3:0]             r_db;
    logic signed [XY_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0]  r_z;
    logic                   r_zero;
    logic signed [H_W-1:0]  r_h;
    logic [8:0]             r_d;
    logic [15:0]            r_n;
    logic [8:0]             r_q;
    logic [8:0]             r_last;
    t_out_word              r_out;

    logic signed [XY_W-1:0] in_x, in_y, x_sh, y_sh;
    logic                   y_pos;
    logic signed [Z_W-1:0]  z_rnd;
    logic signed [15:0]     angle;
    logic [27:0]            div_prod;
    logic [32:0]            rcp_prod;
    logic [8:0]             hi_part;
    logic [8:0]             mapped, smooth;
    logic [9:0]             win_hi, win_lo;

    assign in_x  = {{4{i_in_data.mag_x[15]}}, i_in_data.mag_x, 8'd0};
    assign in_y  = {{4{i_in_data.mag_y[15]}}, i_in_data.mag_y, 8'd0};
    assign x_sh  = r_x >>> i_cmd.step;
    assign y_sh  = r_y >>> i_cmd.step;
    assign y_pos = !r_y[XY_W-1] && (r_y != '0);
    assign z_rnd = r_z + Z_HALF_LSB;
    assign angle = r_zero ? 16'sd0 : z_rnd[Z_W-1:8];

    assign div_prod = 28'(r_h[15:0]) * RECIP_100;
    assign rcp_prod = 33'(r_n) * RECIP_239;

    assign o_sts.h_ok = !r_h[H_W-1] && (r_h < FULL_TURN);

    always_comb begin
        hi_part = 9'(((r_d - MAP_KNEE) * 9'd3) >> 1);
        if (r_d == '0) begin
            mapped = (r_h[15:0] >= HALF_DEG) ? 9'd1 : 9'd0;
        end else if (r_d < MAP_KNEE) begin
            mapped = r_q;
        end else begin
            mapped = MAP_BASE + hi_part;
        end
        win_hi = {1'b0, r_last} + {6'd0, r_db};
        win_lo = {1'b0, mapped} + {6'd0, r_db};
        if (({1'b0, mapped} < win_hi) && (win_lo > {1'b0, r_last})) begin
            smooth = r_last;
        end else begin
            smooth = mapped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl <= DECL_RESET;
            r_db   <= DB_RESET;
            r_last <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DECLINATION: r_decl <= i_cfg_data;
                    CFG_DEADBAND:    r_db   <= i_cfg_data[3:0];
                    default:         ;
                endcase
            end
            if (i_cmd.emit) begin
                r_last <= smooth;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_zero <= (i_in_data.mag_x == '0) && (i_in_data.mag_y == '0);
            if (in_x < 0) begin
                if (in_y >= 0) begin
                    r_x <= in_y;
                    r_y <= -in_x;
                    r_z <= Z_QUARTER;
                end else begin
                    r_x <= -in_y;
                    r_y <= in_x;
                    r_z <= -Z_QUARTER;
                end
            end else begin
                r_x <= in_x;
                r_y <= in_y;
                r_z <= '0;
            end
        end else if (i_cmd.iter) begin
            if (y_pos) begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + chd_atan(i_cmd.step);
            end else begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - chd_atan(i_cmd.step);
            end
        end

        if (i_cmd.angle) begin
            r_h <= {{2{angle[15]}}, angle} - {{2{r_decl[15]}}, r_decl};
        end else if (i_cmd.wrap) begin
            if (r_h[H_W-1]) begin
                r_h <= r_h + FULL_TURN;
            end else begin
                r_h <= r_h - FULL_TURN;
            end
        end

        if (i_cmd.div) begin
            r_d <= div_prod[27:19];
        end
        if (i_cmd.mul) begin
            r_n <= 16'(r_d) * MAP_MUL;
        end
        if (i_cmd.recip) begin
            r_q <= rcp_prod[32:24];
        end
        if (i_cmd.emit) begin
            r_out.heading_fine   <= r_h[15:0];
            r_out.heading_mapped <= mapped;
            r_out.heading_smooth <= smooth;
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire
